@@ hw/rtl/mqpfi_pkg.sv @@
// Shared definitions for the multi-queue front-insert block.
// Holds parameter defaults, request kinds and response status codes.
// No dependencies.
package mqpfi_pkg;

    localparam int DEF_NUM_QUEUES  = 16;
    localparam int DEF_QUEUE_DEPTH = 8;
    localparam int DEF_TAG_WIDTH   = 16;

    localparam int SEL_W   = 4;
    localparam int TAG_W   = 16;
    localparam int COUNT_W = 4;
    localparam int STAT_W  = 2;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_SERVE = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_ADDED  = 2'd0,
        ST_FULL   = 2'd1,
        ST_SERVED = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

endpackage

@@ hw/rtl/multi_queue_priority_front_insert.sv @@
// Bank of bounded circular queues with tail append, urgent head insert and head serve.
// Depends on mqpfi_pkg for status codes, request kinds and parameter defaults.
//
// channel  | dir | tdata                                  | tuser
// ---------+-----+----------------------------------------+--------------------------------
// s_axis   | in  | item_tag[15:0]                         | op[0], queue_sel[4:1], urgent[5]
// m_axis   | out | out_tag[15:0], queue_count[19:16], pad | status[1:0], out_urgent[2]
//
// Requests pass the request, then response stage; one is taken each cycle unless stalled.
// The per-queue head and length registers update in the request stage, and the entry
// memory is read or written at most once per request, single port, read data registered.
// Reset clears all heads and lengths at once; entry contents stay undefined until written.
// A stalled response holds both stages; s_axis_tready falls only when both are occupied.
module multi_queue_priority_front_insert #(
    parameter int NUM_QUEUES  = mqpfi_pkg::DEF_NUM_QUEUES,
    parameter int QUEUE_DEPTH = mqpfi_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_WIDTH   = mqpfi_pkg::DEF_TAG_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // item_tag[15:0]
    input  logic [5:0]  s_axis_tuser,   // op[0], queue_sel[4:1], urgent[5]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_tag[15:0], queue_count[19:16], zero[23:20]
    output logic [2:0]  m_axis_tuser    // status[1:0], out_urgent[2]
);
    import mqpfi_pkg::*;

    localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int SW    = PW + 1;
    localparam int MEM_D = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW    = (MEM_D > 1) ? $clog2(MEM_D) : 1;
    localparam int EW    = TAG_WIDTH + 1;

    // request stage
    logic                 r_in_valid;
    t_op                  r_op;
    logic [SEL_W-1:0]     r_sel;
    logic [TAG_WIDTH-1:0] r_tag;
    logic                 r_urg;

    // response stage
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [CW-1:0]        r_out_count;
    logic                 r_out_served;
    logic [EW-1:0]        r_rd_data;

    // per-queue pointers
    logic [PW-1:0]        r_head [NUM_QUEUES];
    logic [CW-1:0]        r_len  [NUM_QUEUES];

    logic [EW-1:0]        mem [MEM_D];

    logic                 w_out_free;
    logic                 w_fire;
    logic                 w_in_fire;
    logic [TAG_WIDTH-1:0] w_in_tag;
    logic                 w_in_range;
    logic [QW-1:0]        w_idx;
    logic [PW-1:0]        w_head;
    logic [CW-1:0]        w_len;
    logic [PW-1:0]        w_head_dec;
    logic [PW-1:0]        w_head_inc;
    logic [SW-1:0]        w_sum;
    logic [PW-1:0]        w_tail;
    logic [PW-1:0]        w_pos;
    logic [AW-1:0]        w_addr;
    logic                 w_wr_en;
    logic                 w_rd_en;
    logic                 w_upd;
    t_status              n_status;
    logic [PW-1:0]        n_head;
    logic [CW-1:0]        n_len;
    logic [CW-1:0]        n_count;
    logic [TAG_W-1:0]     w_out_tag;
    logic [COUNT_W-1:0]   w_out_count;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    for (genvar i = 0; i < TAG_WIDTH; i++) begin : g_in_tag
        if (i < TAG_W) begin : g_bit
            assign w_in_tag[i] = s_axis_tdata[i];
        end else begin : g_zero
            assign w_in_tag[i] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (w_in_fire) begin
            r_op  <= t_op'(s_axis_tuser[0]);
            r_sel <= s_axis_tuser[SEL_W:1];
            r_tag <= w_in_tag;
            r_urg <= s_axis_tuser[SEL_W+1];
        end
    end

    assign w_in_range = (32'(r_sel) < NUM_QUEUES);
    assign w_idx      = QW'(r_sel);
    assign w_head     = w_in_range ? r_head[w_idx] : '0;
    assign w_len      = w_in_range ? r_len[w_idx] : '0;
    assign w_head_dec = (w_head == '0) ? PW'(QUEUE_DEPTH - 1) : w_head - PW'(1);
    assign w_head_inc = (w_head == PW'(QUEUE_DEPTH - 1)) ? '0 : w_head + PW'(1);
    assign w_sum      = SW'(w_head) + SW'(w_len);
    assign w_tail     = (w_sum >= SW'(QUEUE_DEPTH)) ? PW'(w_sum - SW'(QUEUE_DEPTH))
                                                    : PW'(w_sum);

    always_comb begin
        n_status = ST_EMPTY;
        n_head   = w_head;
        n_len    = w_len;
        w_pos    = w_head;
        w_wr_en  = 1'b0;
        w_rd_en  = 1'b0;
        w_upd    = 1'b0;
        unique case (r_op)
            OP_ADD: begin
                if (!w_in_range || w_len >= CW'(QUEUE_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_ADDED;
                    w_pos    = r_urg ? w_head_dec : w_tail;
                    n_head   = r_urg ? w_head_dec : w_head;
                    n_len    = w_len + CW'(1);
                    w_wr_en  = w_fire;
                    w_upd    = w_fire;
                end
            end
            OP_SERVE: begin
                if (!w_in_range || w_len == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status = ST_SERVED;
                    n_head   = w_head_inc;
                    n_len    = w_len - CW'(1);
                    w_rd_en  = w_fire;
                    w_upd    = w_fire;
                end
            end
            default: n_status = ST_EMPTY;
        endcase
        n_count = w_in_range ? n_len : '0;
    end

    assign w_addr = AW'(w_idx) * AW'(QUEUE_DEPTH) + AW'(w_pos);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_addr] <= {r_urg, r_tag};
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_len[i]  <= '0;
            end
        end else if (w_upd) begin
            r_head[w_idx] <= n_head;
            r_len[w_idx]  <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (w_fire) begin
            r_out_status <= n_status;
            r_out_count  <= n_count;
            r_out_served <= (n_status == ST_SERVED);
        end
    end

    for (genvar i = 0; i < TAG_W; i++) begin : g_out_tag
        if (i < TAG_WIDTH) begin : g_bit
            assign w_out_tag[i] = r_out_served & r_rd_data[i];
        end else begin : g_zero
            assign w_out_tag[i] = 1'b0;
        end
    end

    for (genvar i = 0; i < COUNT_W; i++) begin : g_out_count
        if (i < CW) begin : g_bit
            assign w_out_count[i] = r_out_count[i];
        end else begin : g_zero
            assign w_out_count[i] = 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, w_out_count, w_out_tag};
    assign m_axis_tuser  = {r_out_served & r_rd_data[TAG_WIDTH], r_out_status};

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> w_len <= CW'(QUEUE_DEPTH))
        else $error("queue length above depth");

    a_added_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_ADDED |-> r_out_count != '0)
        else $error("added response with zero count");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_EMPTY |-> r_out_count == '0)
        else $error("empty response with nonzero count");

    a_hold_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_out_free |=> r_in_valid && $stable(r_sel) && $stable(r_op))
        else $error("stalled request lost");

    a_served_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_op == OP_SERVE && w_in_range && w_len != '0 |=> r_out_served)
        else $error("serve of nonempty queue not flagged");

endmodule

@@ verif/multi_queue_priority_front_insert_test.sv @@
// Self-checking testbench for multi_queue_priority_front_insert.
// Predicts each response from a shadow copy of the queue bank, with directed and random traffic.
// Depends on mqpfi_pkg and the block under test.
`timescale 1ns / 1ps

module multi_queue_priority_front_insert_test;
    import mqpfi_pkg::*;

    localparam int NUM_Q       = DEF_NUM_QUEUES;
    localparam int DEPTH       = DEF_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT = 200_000;

    typedef struct {
        t_status            status;
        logic [TAG_W-1:0]   tag;
        logic               urgent;
        logic [COUNT_W-1:0] count;
    } t_response;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // item_tag[15:0]
    logic [5:0]  s_axis_tuser;   // op[0], queue_sel[4:1], urgent[5]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;   // out_tag[15:0], queue_count[19:16], zero[23:20]
    logic [2:0]  m_axis_tuser;   // status[1:0], out_urgent[2]

    logic [TAG_W-1:0]   slot_tag    [NUM_Q][DEPTH];
    logic               slot_urgent [NUM_Q][DEPTH];
    int                 head_slot   [NUM_Q];
    int                 fill_level  [NUM_Q];

    t_response pending[$];
    t_response next_due;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        error_count    = 0;
    int        requests_sent  = 0;
    int        served_count   = 0;
    int        full_count     = 0;
    int        empty_count    = 0;
    int        cycle_count    = 0;

    multi_queue_priority_front_insert dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycle_count, pending.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_response predict_response(input t_op op, input int sel,
                                                    input logic [TAG_W-1:0] tag,
                                                    input logic urg);
        t_response r;
        int        pos;
        r.status = ST_EMPTY;
        r.tag    = '0;
        r.urgent = 1'b0;
        r.count  = '0;
        if (sel >= NUM_Q) begin
            r.status = (op == OP_ADD) ? ST_FULL : ST_EMPTY;
            return r;
        end
        if (op == OP_ADD) begin
            if (fill_level[sel] >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                if (urg) begin
                    head_slot[sel] = (head_slot[sel] + DEPTH - 1) % DEPTH;
                    pos = head_slot[sel];
                end else begin
                    pos = (head_slot[sel] + fill_level[sel]) % DEPTH;
                end
                slot_tag[sel][pos]    = tag;
                slot_urgent[sel][pos] = urg;
                fill_level[sel]++;
                r.status = ST_ADDED;
            end
        end else if (fill_level[sel] == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.tag    = slot_tag[sel][head_slot[sel]];
            r.urgent = slot_urgent[sel][head_slot[sel]];
            head_slot[sel] = (head_slot[sel] + 1) % DEPTH;
            fill_level[sel]--;
            r.status = ST_SERVED;
        end
        r.count = COUNT_W'(fill_level[sel]);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending.size() == 0) begin
                $error("unexpected response: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                next_due = pending.pop_front();
                if (m_axis_tuser[1:0] !== next_due.status) begin
                    $error("status: expected %0d, actual %0d", next_due.status,
                           m_axis_tuser[1:0]);
                    error_count++;
                end
                if (m_axis_tdata[15:0] !== next_due.tag) begin
                    $error("out_tag: expected %h, actual %h", next_due.tag, m_axis_tdata[15:0]);
                    error_count++;
                end
                if (m_axis_tuser[2] !== next_due.urgent) begin
                    $error("out_urgent: expected %0d, actual %0d", next_due.urgent,
                           m_axis_tuser[2]);
                    error_count++;
                end
                if (m_axis_tdata[19:16] !== next_due.count) begin
                    $error("queue_count: expected %0d, actual %0d", next_due.count,
                           m_axis_tdata[19:16]);
                    error_count++;
                end
                if (m_axis_tdata[23:20] !== 4'd0) begin
                    $error("pad: expected 0, actual %h", m_axis_tdata[23:20]);
                    error_count++;
                end
                case (next_due.status)
                    ST_SERVED: served_count++;
                    ST_FULL:   full_count++;
                    ST_EMPTY:  empty_count++;
                    default: ;
                endcase
            end
        end
    end

    task automatic send_request(input t_op op, input logic [SEL_W-1:0] sel,
                                input logic [TAG_W-1:0] tag, input logic urg);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tag;
        s_axis_tuser  <= {urg, sel, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        pending.push_back(predict_response(op, int'(sel), tag, urg));
        requests_sent++;
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_fill_and_overflow();
        for (int i = 0; i < DEPTH; i++) begin
            send_request(OP_ADD, 4'd0, TAG_W'(16'h1000 + i), 1'b0);
        end
        send_request(OP_ADD, 4'd0, 16'h0000, 1'b0);
        send_request(OP_ADD, 4'd0, 16'hFFFF, 1'b1);
        for (int i = 0; i <= DEPTH; i++) begin
            send_request(OP_SERVE, 4'd0, TAG_W'($urandom_range(16'hFFFF)),
                         1'($urandom_range(1)));
        end
        wait_until_drained();
    endtask

    task automatic test_urgent_front();
        send_request(OP_ADD, 4'd15, 16'hFFFF, 1'b1);
        send_request(OP_ADD, 4'd15, 16'h0000, 1'b0);
        send_request(OP_ADD, 4'd15, 16'h5A5A, 1'b1);
        for (int i = 0; i < 3; i++) begin
            send_request(OP_SERVE, 4'd15, 16'h0000, 1'b0);
        end
        wait_until_drained();
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        logic [SEL_W-1:0] hot_a;
        logic [SEL_W-1:0] hot_b;
        logic [SEL_W-1:0] sel;
        t_op              op;
        int               add_pct;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hot_a   = SEL_W'($urandom_range(NUM_Q - 1));
        hot_b   = SEL_W'($urandom_range(NUM_Q - 1));
        add_pct = 50;
        for (int i = 0; i < n_items; i++) begin
            if (i % 24 == 0) add_pct = int'($urandom_range(85, 15));
            if (i == n_items / 2) wait_until_drained();
            case ($urandom_range(3))
                0:       sel = SEL_W'($urandom_range(NUM_Q - 1));
                1:       sel = hot_b;
                default: sel = hot_a;
            endcase
            if ($urandom_range(99) < add_pct) op = OP_ADD;
            else                              op = OP_SERVE;
            send_request(op, sel, TAG_W'($urandom_range(16'hFFFF)), ($urandom_range(2) == 0));
        end
        wait_until_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        for (int q = 0; q < NUM_Q; q++) begin
            head_slot[q]  = 0;
            fill_level[q] = 0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_fill_and_overflow();
        test_urgent_front();
        test_random_traffic(175, 0, 0);
        test_random_traffic(175, 64, 0);
        test_random_traffic(175, 0, 64);
        test_random_traffic(175, 35, 35);

        recv_stall_pct = 0;
        repeat (10) @(negedge i_clk);
        $display("Checked %0d requests across %0d queues of depth %0d", requests_sent,
                 NUM_Q, DEPTH);
        $display("Saw %0d serves, %0d full refusals, %0d empty serves", served_count,
                 full_count, empty_count);
        if (error_count == 0 && pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
